### design/crd_pkg.sv
// crd_pkg: shared types, constants and status codes of the checked record decoder.
// Used by crd_judge and checked_record_decoder_core; depends on nothing else.
`timescale 1ns / 1ps

package crd_pkg;

    // Frame geometry
    localparam int FRAME_BYTES        = 16;
    localparam int LEGACY_FRAME_BYTES = 13;
    localparam int COUNT_SAT          = FRAME_BYTES + 1;
    localparam int SNAP_NINE          = 9;
    localparam int SNAP_TWELVE        = 12;
    localparam int MIN_FRAME_BYTES    = 5;

    // Hash and format constants
    localparam logic [31:0] MAGIC_WORD   = 32'h5043_584E;
    localparam logic [31:0] HASH_BASIS   = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME   = 32'd16777619;
    localparam logic [7:0]  LEVEL_MAX    = 8'd100;
    localparam logic [6:0]  LEGACY_TRUST = 7'd20;
    localparam logic [7:0]  LEGACY_VERSION        = 8'd1;
    localparam logic [7:0]  CURRENT_VERSION_RESET = 8'd2;

    // Status codes
    localparam logic [1:0] STATUS_INVALID  = 2'd0;
    localparam logic [1:0] STATUS_LOADED   = 2'd1;
    localparam logic [1:0] STATUS_MIGRATED = 2'd2;

    // Register index of current_version
    localparam logic REG_CURRENT_VERSION = 1'b0;

    typedef logic [4:0] count_t;
    typedef logic [FRAME_BYTES-1:0][7:0] store_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  energy;
        logic [6:0]  joy;
        logic [6:0]  trust;
        logic [31:0] interactions;
    } result_t;

endpackage

### design/checked_record_decoder_core.sv
// Checked record decoder: byte-stream frame parser with FNV-1a 32-bit hash check.
// A byte accepted from the channel is held in the input register; a frame's result is
// captured in the output register as its final byte leaves, once that register has room.
// Throughput: one byte per cycle while no final byte waits; the hash step (XOR, constant multiply) sets it.
// Reset: control, count and snapshots clear, hash to basis, version register to 2;
// the frame store has no reset and no clearing pass.
`timescale 1ns / 1ps

module checked_record_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,

    // Byte input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [6:0]  energy,
    output logic [6:0]  joy,
    output logic [6:0]  trust,
    output logic [31:0] interactions,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                s1_valid_reg;
    logic [7:0]          s1_data_reg;
    logic                s1_last_reg;
    logic                s1_fire;
    logic                out_free;

    crd_pkg::store_t     store_reg;
    crd_pkg::store_t     store_next;
    crd_pkg::count_t     count_reg;
    crd_pkg::count_t     count_next;
    logic [31:0]         hash_reg;
    logic [31:0]         hash_next;
    logic [31:0]         nine_reg;
    logic [31:0]         nine_next;
    logic [31:0]         twelve_reg;
    logic [31:0]         twelve_next;
    logic                store_write;

    logic [7:0]          version_reg;
    logic                out_valid_reg;
    crd_pkg::result_t    result_reg;
    crd_pkg::result_t    judge_result;

    // Configuration register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == crd_pkg::REG_CURRENT_VERSION) ? {24'd0, version_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            version_reg <= crd_pkg::CURRENT_VERSION_RESET;
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == crd_pkg::REG_CURRENT_VERSION))
            version_reg <= pwdata[7:0];
    end

    // Handshake: a final byte waits for room in the output register
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Store, hash and counter update for the byte in the input register
    assign store_write = count_reg < 5'(crd_pkg::FRAME_BYTES);
    assign hash_next   = store_write ? (hash_reg ^ {24'd0, s1_data_reg}) * crd_pkg::HASH_PRIME
                                     : hash_reg;
    assign count_next  = (count_reg < 5'(crd_pkg::COUNT_SAT)) ? count_reg + 5'd1 : count_reg;
    assign nine_next   = (count_next == 5'(crd_pkg::SNAP_NINE)) ? hash_next : nine_reg;
    assign twelve_next = (count_next == 5'(crd_pkg::SNAP_TWELVE)) ? hash_next : twelve_reg;

    always_comb
    begin
        store_next = store_reg;
        if (store_write)
            store_next[count_reg[3:0]] = s1_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            store_reg <= store_next;
    end

    // Frame state; returns to reset values after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            hash_reg   <= crd_pkg::HASH_BASIS;
            nine_reg   <= 32'd0;
            twelve_reg <= 32'd0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                count_reg  <= '0;
                hash_reg   <= crd_pkg::HASH_BASIS;
                nine_reg   <= 32'd0;
                twelve_reg <= 32'd0;
            end
            else
            begin
                count_reg  <= count_next;
                hash_reg   <= hash_next;
                nine_reg   <= nine_next;
                twelve_reg <= twelve_next;
            end
        end
    end

    // Snapshots never change on a byte that completes a valid frame,
    // so the registered values feed the check directly
    crd_judge u_judge
    (
        .store           (store_next),
        .count           (count_next),
        .hash_nine       (nine_reg),
        .hash_twelve     (twelve_reg),
        .current_version (version_reg),
        .result          (judge_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
            result_reg <= judge_result;
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign energy       = result_reg.energy;
    assign joy          = result_reg.joy;
    assign trust        = result_reg.trust;
    assign interactions = result_reg.interactions;

`ifndef SYNTH
    // Byte counter stays within its saturation limit
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 5'(crd_pkg::COUNT_SAT))
        else $error("byte counter beyond saturation");

    // A final byte leaves the frame state at its reset values
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> count_reg == 5'd0 && hash_reg == crd_pkg::HASH_BASIS
                                   && nine_reg == 32'd0 && twelve_reg == 32'd0)
        else $error("frame state not cleared after final byte");

    // Invalid results carry zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.status == crd_pkg::STATUS_INVALID
        |-> result_reg.energy == 7'd0 && result_reg.joy == 7'd0
            && result_reg.trust == 7'd0 && result_reg.interactions == 32'd0)
        else $error("invalid result with non-zero fields");

    // A held input register keeps its byte
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_data_reg)
                                     && $stable(s1_last_reg))
        else $error("stalled input register changed");
`endif

endmodule

### design/crd_judge.sv
// crd_judge: combinational frame check (magic, version, length, hash, levels).
// Depends on crd_pkg for the store and result types and the format constants.
`timescale 1ns / 1ps

module crd_judge
(
    input  crd_pkg::store_t  store,
    input  crd_pkg::count_t  count,
    input  logic [31:0]      hash_nine,
    input  logic [31:0]      hash_twelve,
    input  logic [7:0]       current_version,
    output crd_pkg::result_t result
);

    logic        magic_ok;
    logic        length_ok;
    logic        is_current;
    logic        is_legacy;
    logic        current_hash_ok;
    logic        legacy_hash_ok;
    logic [7:0]  energy_byte;
    logic [7:0]  joy_byte;
    logic [7:0]  trust_byte;
    logic [31:0] count_field;
    logic        levels_ok;
    logic        accepted;

    // Header and length checks; the current format takes precedence
    assign magic_ok  = {store[3], store[2], store[1], store[0]} == crd_pkg::MAGIC_WORD;
    assign length_ok = (count >= 5'(crd_pkg::MIN_FRAME_BYTES))
                    && (count <= 5'(crd_pkg::FRAME_BYTES));
    assign is_current = (store[4] == current_version)
                     && (count == 5'(crd_pkg::FRAME_BYTES));
    assign is_legacy  = !is_current && (store[4] == crd_pkg::LEGACY_VERSION)
                     && (count == 5'(crd_pkg::LEGACY_FRAME_BYTES));

    // Stored hash words, little-endian
    assign current_hash_ok = {store[15], store[14], store[13], store[12]} == hash_twelve;
    assign legacy_hash_ok  = {store[12], store[11], store[10], store[9]} == hash_nine;

    // Field selection per format
    assign energy_byte = store[5];
    assign joy_byte    = store[6];
    assign trust_byte  = is_current ? store[7] : {1'b0, crd_pkg::LEGACY_TRUST};
    assign count_field = is_current ? {store[11], store[10], store[9], store[8]}
                                    : {16'd0, store[8], store[7]};

    assign levels_ok = (energy_byte <= crd_pkg::LEVEL_MAX)
                    && (joy_byte <= crd_pkg::LEVEL_MAX)
                    && (trust_byte <= crd_pkg::LEVEL_MAX);

    assign accepted = magic_ok && length_ok && levels_ok
                   && ((is_current && current_hash_ok) || (is_legacy && legacy_hash_ok));

    // Invalid frames report all fields as zero
    always_comb
    begin
        if (accepted)
        begin
            result.status       = is_current ? crd_pkg::STATUS_LOADED
                                             : crd_pkg::STATUS_MIGRATED;
            result.energy       = energy_byte[6:0];
            result.joy          = joy_byte[6:0];
            result.trust        = trust_byte[6:0];
            result.interactions = count_field;
        end
        else
        begin
            result.status       = crd_pkg::STATUS_INVALID;
            result.energy       = 7'd0;
            result.joy          = 7'd0;
            result.trust        = 7'd0;
            result.interactions = 32'd0;
        end
    end

endmodule

### dv/testbench.sv
// testbench: self-checking bench for checked_record_decoder_core, with frame generator,
// scoreboard predictor, burst driver, stalling monitor and APB register access.
// Depends on crd_pkg and checked_record_decoder_core from the design folder.
`timescale 1ns / 1ps

module testbench;

    localparam int          CLK_HALF_NS          = 5;
    localparam int          RESET_CYCLES         = 6;
    localparam int          SETTLE_CYCLES        = 6;
    localparam int          CYCLE_LIMIT          = 400000;
    localparam int          RANDOM_PHASES        = 6;
    localparam int          BYTES_PER_PHASE      = 275;
    localparam int          MAX_REPORTED         = 10;
    localparam logic [2:0]  ADDR_CURRENT_VERSION = {crd_pkg::REG_CURRENT_VERSION, 2'b00};
    localparam logic [2:0]  ADDR_UNMAPPED        = 3'd4;

    // DUT input ports, all known from time zero
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte    = '0;
    logic        last_byte    = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [1:0]  status;
    logic [6:0]  energy;
    logic [6:0]  joy;
    logic [6:0]  trust;
    logic [31:0] interactions;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus and scoreboard storage
    logic [8:0]        pending_bytes[$];     // {last, data}
    logic [7:0]        frame_buf[$];
    crd_pkg::result_t  expected_results[$];
    logic [7:0]        gen_version = crd_pkg::CURRENT_VERSION_RESET;
    int                mismatch_count = 0;
    int                cycle_count = 0;

    // Predictor state
    logic [7:0]  p_store[crd_pkg::FRAME_BYTES];
    logic [4:0]  p_count   = '0;
    logic [31:0] p_hash    = crd_pkg::HASH_BASIS;
    logic [31:0] p_snap9   = '0;
    logic [31:0] p_snap12  = '0;
    logic [7:0]  p_version = crd_pkg::CURRENT_VERSION_RESET;

    // Driver and monitor pacing
    int                burst_left = 1;
    int                gap_left   = 0;
    logic [8:0]        next_item;
    int                stall_mode = 0;
    int                stall_phase = 0;
    crd_pkg::result_t  want;

    checked_record_decoder_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .energy       (energy),
        .joy          (joy),
        .trust        (trust),
        .interactions (interactions),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #CLK_HALF_NS clk = ~clk;

    // One FNV-1a step
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        return (h ^ {24'd0, b}) * crd_pkg::HASH_PRIME;
    endfunction

    function automatic logic [31:0] store_word(input int pos);
        return {p_store[pos+3], p_store[pos+2], p_store[pos+1], p_store[pos]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("mismatch on %s: expected %0h, got %0h", what, want_v, got_v);
    endtask

    // Predictor: take one accepted byte, queue the verdict on the final byte
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        crd_pkg::result_t r;
        logic [1:0]  st;
        logic [7:0]  en;
        logic [7:0]  jo;
        logic [7:0]  tr;
        logic [31:0] cnt;
        if (p_count < crd_pkg::FRAME_BYTES)
        begin
            p_store[p_count[3:0]] = b;
            p_hash = fnv_step(p_hash, b);
        end
        if (p_count < crd_pkg::COUNT_SAT)
            p_count++;
        if (p_count == crd_pkg::SNAP_NINE)
            p_snap9 = p_hash;
        if (p_count == crd_pkg::SNAP_TWELVE)
            p_snap12 = p_hash;
        if (fin)
        begin
            st = crd_pkg::STATUS_INVALID;
            en = '0;
            jo = '0;
            tr = '0;
            cnt = '0;
            if (p_count >= crd_pkg::MIN_FRAME_BYTES && p_count <= crd_pkg::FRAME_BYTES &&
                store_word(0) == crd_pkg::MAGIC_WORD)
            begin
                // current format is tried first, so version 1 can mean either
                if (p_store[4] == p_version && p_count == crd_pkg::FRAME_BYTES)
                begin
                    if (store_word(12) == p_snap12)
                    begin
                        st = crd_pkg::STATUS_LOADED;
                        en = p_store[5];
                        jo = p_store[6];
                        tr = p_store[7];
                        cnt = store_word(8);
                    end
                end
                else if (p_store[4] == crd_pkg::LEGACY_VERSION
                         && p_count == crd_pkg::LEGACY_FRAME_BYTES)
                begin
                    if (store_word(9) == p_snap9)
                    begin
                        st = crd_pkg::STATUS_MIGRATED;
                        en = p_store[5];
                        jo = p_store[6];
                        tr = {1'b0, crd_pkg::LEGACY_TRUST};
                        cnt = {16'd0, p_store[8], p_store[7]};
                    end
                end
                if (st != crd_pkg::STATUS_INVALID
                    && (en > crd_pkg::LEVEL_MAX || jo > crd_pkg::LEVEL_MAX
                        || tr > crd_pkg::LEVEL_MAX))
                    st = crd_pkg::STATUS_INVALID;
            end
            if (st == crd_pkg::STATUS_INVALID)
            begin
                en = '0;
                jo = '0;
                tr = '0;
                cnt = '0;
            end
            r.status = st;
            r.energy = en[6:0];
            r.joy = jo[6:0];
            r.trust = tr[6:0];
            r.interactions = cnt;
            expected_results.push_back(r);
            p_count = '0;
            p_hash = crd_pkg::HASH_BASIS;
            p_snap9 = '0;
            p_snap12 = '0;
        end
    endtask

    // Frame builders
    task automatic push_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            frame_buf.push_back(w[8*k +: 8]);
    endtask

    task automatic build_current(input logic [7:0] ver, input logic [7:0] en,
                                 input logic [7:0] jo, input logic [7:0] tr,
                                 input logic [31:0] cnt);
        logic [31:0] h;
        frame_buf.delete();
        push_word(crd_pkg::MAGIC_WORD);
        frame_buf.push_back(ver);
        frame_buf.push_back(en);
        frame_buf.push_back(jo);
        frame_buf.push_back(tr);
        push_word(cnt);
        h = crd_pkg::HASH_BASIS;
        for (int i = 0; i < crd_pkg::SNAP_TWELVE; i++)
            h = fnv_step(h, frame_buf[i]);
        push_word(h);
    endtask

    task automatic build_legacy(input logic [7:0] en, input logic [7:0] jo,
                                input logic [15:0] cnt);
        logic [31:0] h;
        frame_buf.delete();
        push_word(crd_pkg::MAGIC_WORD);
        frame_buf.push_back(crd_pkg::LEGACY_VERSION);
        frame_buf.push_back(en);
        frame_buf.push_back(jo);
        frame_buf.push_back(cnt[7:0]);
        frame_buf.push_back(cnt[15:8]);
        h = crd_pkg::HASH_BASIS;
        for (int i = 0; i < crd_pkg::SNAP_NINE; i++)
            h = fnv_step(h, frame_buf[i]);
        push_word(h);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            pending_bytes.push_back({i == frame_buf.size() - 1, frame_buf[i]});
    endtask

    function automatic logic [7:0] random_level();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return 8'($urandom_range(crd_pkg::LEVEL_MAX + 1, 255));
        else if (pick == 1)
            return crd_pkg::LEVEL_MAX;
        else if (pick == 2)
            return 8'd0;
        return 8'($urandom_range(0, crd_pkg::LEVEL_MAX));
    endfunction

    // Mostly well-formed frames, the rest broken or noise
    task automatic random_frame();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 50 || (sel >= 75 && sel < 90))
        begin
            if ($urandom_range(0, 1) == 0)
                build_current(gen_version, random_level(), random_level(), random_level(),
                              $urandom);
            else
                build_legacy(random_level(), random_level(), 16'($urandom));
        end
        if (sel >= 50 && sel < 75)
        begin
            if ($urandom_range(0, 1) == 0)
                build_current(gen_version, random_level(), random_level(), random_level(),
                              $urandom);
            else
                build_legacy(random_level(), random_level(), 16'($urandom));
        end
        if (sel >= 75 && sel < 83)
        begin
            // one corrupted byte
            len = frame_buf.size();
            frame_buf[$urandom_range(0, len - 1)] ^= 8'($urandom_range(1, 255));
        end
        else if (sel >= 83 && sel < 87)
        begin
            // truncated
            len = $urandom_range(1, 4);
            repeat (len) void'(frame_buf.pop_back());
        end
        else if (sel >= 87 && sel < 90)
        begin
            // overlong, up to well past saturation
            len = $urandom_range(1, 8);
            repeat (len) frame_buf.push_back(8'($urandom));
        end
        else if (sel >= 90 && sel < 94)
        begin
            build_current(8'($urandom), random_level(), random_level(), random_level(),
                          $urandom);
        end
        else if (sel >= 94)
        begin
            frame_buf.delete();
            len = $urandom_range(1, 22);
            if ($urandom_range(0, 1) == 0)
                push_word(crd_pkg::MAGIC_WORD);
            repeat (len) frame_buf.push_back(8'($urandom));
        end
        send_frame();
    endtask

    // APB write, then read back
    task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
        logic [7:0] got;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {8'($urandom), 8'($urandom), 8'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_CURRENT_VERSION)
        begin
            p_version = value;
            gen_version = value;
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_CURRENT_VERSION;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata[7:0];
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== p_version)
            report_mismatch("current_version readback", {24'd0, p_version}, {24'd0, got});
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Byte driver: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_byte(data_byte, last_byte);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || pending_bytes.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_item = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= next_item[7:0];
                    last_byte <= next_item[8];
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", '0, interactions);
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", {30'd0, want.status}, {30'd0, status});
                    if (energy !== want.energy)
                        report_mismatch("energy", {25'd0, want.energy}, {25'd0, energy});
                    if (joy !== want.joy)
                        report_mismatch("joy", {25'd0, want.joy}, {25'd0, joy});
                    if (trust !== want.trust)
                        report_mismatch("trust", {25'd0, want.trust}, {25'd0, trust});
                    if (interactions !== want.interactions)
                        report_mismatch("interactions", want.interactions, interactions);
                end
            end
            // new stall mode each time the stall phase wraps: none, random, periodic, heavy
            stall_phase++;
            if (stall_phase == 128)
            begin
                stall_phase = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (stall_phase % 5) != 0;
                default: out_ready <= (stall_phase % 8) == 0;
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("checked_record_decoder_core verification failed");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset version
        build_current(gen_version, 8'd0, 8'd0, 8'd0, 32'd0);
        send_frame();
        build_current(gen_version, crd_pkg::LEVEL_MAX, crd_pkg::LEVEL_MAX,
                      crd_pkg::LEVEL_MAX, 32'hFFFF_FFFF);
        send_frame();
        build_current(gen_version, crd_pkg::LEVEL_MAX + 8'd1, 8'd50, 8'd50, 32'h1234_5678);
        send_frame();
        build_current(gen_version, 8'd10, 8'd20, 8'd255, 32'h0000_0001);
        send_frame();
        build_legacy(8'd0, 8'd0, 16'h0000);
        send_frame();
        build_legacy(crd_pkg::LEVEL_MAX, crd_pkg::LEVEL_MAX, 16'hFFFF);
        send_frame();
        build_legacy(8'd255, 8'd0, 16'h8001);
        send_frame();
        // bad hash, bad magic
        build_current(gen_version, 8'd1, 8'd2, 8'd3, 32'hA5A5_5A5A);
        frame_buf[13] ^= 8'h01;
        send_frame();
        build_legacy(8'd7, 8'd8, 16'h0102);
        frame_buf[0] ^= 8'h80;
        send_frame();
        // short frames: one byte, magic only, magic plus version
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame();
        frame_buf.delete();
        push_word(crd_pkg::MAGIC_WORD);
        send_frame();
        frame_buf.push_back(gen_version);
        send_frame();
        // overlong: one extra byte, then far past saturation
        build_current(gen_version, 8'd5, 8'd5, 8'd5, 32'd5);
        frame_buf.push_back(8'h00);
        send_frame();
        build_current(gen_version, 8'd5, 8'd5, 8'd5, 32'd5);
        repeat (14) frame_buf.push_back(8'($urandom));
        send_frame();
        // legacy length with current version byte, current length with legacy version
        build_legacy(8'd3, 8'd4, 16'h0505);
        frame_buf[4] = gen_version;
        send_frame();
        build_current(crd_pkg::LEGACY_VERSION, 8'd3, 8'd4, 8'd5, 32'd6);
        send_frame();
        wait_drained();

        // Version ambiguity: both formats carry version 1
        write_register(ADDR_CURRENT_VERSION, crd_pkg::LEGACY_VERSION);
        build_current(gen_version, 8'd11, 8'd22, 8'd33, 32'hDEAD_BEEF);
        send_frame();
        build_legacy(8'd44, 8'd55, 16'hBEEF);
        send_frame();
        wait_drained();

        // Write to an unmapped register must leave the version alone
        write_register(ADDR_UNMAPPED, 8'd7);
        build_current(crd_pkg::LEGACY_VERSION, 8'd1, 8'd1, 8'd1, 32'd1);
        send_frame();
        build_current(8'd7, 8'd1, 8'd1, 8'd1, 32'd1);
        send_frame();
        wait_drained();

        // Random phases over several version settings, extremes included
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: write_register(ADDR_CURRENT_VERSION, 8'd0);
                1: write_register(ADDR_CURRENT_VERSION, 8'd255);
                2: write_register(ADDR_CURRENT_VERSION, crd_pkg::CURRENT_VERSION_RESET);
                3: write_register(ADDR_CURRENT_VERSION, crd_pkg::LEGACY_VERSION);
                default: write_register(ADDR_CURRENT_VERSION, 8'($urandom));
            endcase
            for (int sent = 0; sent < BYTES_PER_PHASE; )
            begin
                random_frame();
                sent += frame_buf.size();
            end
            wait_drained();
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("checked_record_decoder_core verification clean");
        else
            $display("checked_record_decoder_core verification failed");
        $finish;
    end

endmodule
